// ===== sv/ida_pkg.sv =====
// shared types and constants for the id allocator
// used by ida_ctrl, ida_dp and the top level id_allocator_with_recycle_list
package ida_pkg;

  localparam int MAX_IDS = 1024;
  localparam int ID_W    = $clog2(MAX_IDS);
  localparam int CNT_W   = ID_W + 1;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_ABOVE = 2'd1,
    ACT_FRESH = 2'd2,
    ACT_FREE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_INVALID   = 2'd2
  } status_t;

  typedef struct packed {
    action_t           action;
    logic [ID_W-1:0]   entity_id;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]   result_id;
    status_t           status;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR
  } state_t;

  typedef enum logic [2:0] {
    RES_FRESH,
    RES_RDDATA,
    RES_FOUND,
    RES_ARG,
    RES_EXHAUSTED,
    RES_INVALID
  } res_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     load;
    logic     rd_en;
    logic     rd_head;
    logic     idx_clr;
    logic     idx_inc;
    logic     wr_shift;
    logic     append;
    logic     pop;
    logic     drop;
    logic     take_fresh;
    logic     hold_found;
    logic     finish;
    res_sel_t res_sel;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    action_t action;
    logic    count_zero;
    logic    fresh_left;
    logic    arg_zero;
    logic    arg_ge_fresh;
    logic    rd_gt_arg;
    logic    rd_eq_arg;
    logic    idx_last;
  } dp_stat_t;

endpackage

// ===== sv/ida_ctrl.sv =====
// controller state machine for the id allocator
// depends on ida_pkg; drives ida_dp through dp_cmd_t, reads dp_stat_t
module ida_ctrl
  import ida_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (stat.action)
          ACT_ALLOC: state_next = stat.count_zero ? S_IDLE : S_POP;
          ACT_FRESH: state_next = S_IDLE;
          ACT_ABOVE: begin
            if (stat.arg_ge_fresh || stat.count_zero) state_next = S_IDLE;
            else state_next = S_SCAN_RD;
          end
          ACT_FREE: begin
            if (stat.arg_zero || stat.arg_ge_fresh || stat.count_zero) state_next = S_IDLE;
            else state_next = S_SCAN_RD;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_POP:     state_next = S_IDLE;
      S_SCAN_RD: state_next = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (stat.action == ACT_ABOVE) begin
          if (stat.rd_gt_arg) state_next = stat.idx_last ? S_IDLE : S_SHIFT_RD;
          else state_next = stat.idx_last ? S_IDLE : S_SCAN_RD;
        end else begin
          if (stat.rd_eq_arg || stat.idx_last) state_next = S_IDLE;
          else state_next = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: state_next = S_SHIFT_WR;
      S_SHIFT_WR: state_next = stat.idx_last ? S_IDLE : S_SHIFT_RD;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.res_sel = RES_INVALID;
    unique case (state)
      S_IDLE: begin
        cmd.load = start;
      end
      S_DISPATCH: begin
        unique case (stat.action)
          ACT_ALLOC: begin
            if (stat.count_zero) begin
              cmd.finish     = 1'b1;
              cmd.take_fresh = stat.fresh_left;
              cmd.res_sel    = stat.fresh_left ? RES_FRESH : RES_EXHAUSTED;
            end else begin
              cmd.rd_en   = 1'b1;
              cmd.rd_head = 1'b1;
            end
          end
          ACT_FRESH: begin
            cmd.finish     = 1'b1;
            cmd.take_fresh = stat.fresh_left;
            cmd.res_sel    = stat.fresh_left ? RES_FRESH : RES_EXHAUSTED;
          end
          ACT_ABOVE: begin
            if (stat.arg_ge_fresh) begin
              cmd.finish  = 1'b1;
              cmd.res_sel = RES_INVALID;
            end else if (stat.count_zero) begin
              cmd.finish     = 1'b1;
              cmd.take_fresh = stat.fresh_left;
              cmd.res_sel    = stat.fresh_left ? RES_FRESH : RES_EXHAUSTED;
            end else begin
              cmd.idx_clr = 1'b1;
            end
          end
          ACT_FREE: begin
            if (stat.arg_zero || stat.arg_ge_fresh) begin
              cmd.finish  = 1'b1;
              cmd.res_sel = RES_INVALID;
            end else if (stat.count_zero) begin
              cmd.finish  = 1'b1;
              cmd.append  = 1'b1;
              cmd.res_sel = RES_ARG;
            end else begin
              cmd.idx_clr = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_POP: begin
        cmd.finish  = 1'b1;
        cmd.pop     = 1'b1;
        cmd.res_sel = RES_RDDATA;
      end
      S_SCAN_RD: begin
        cmd.rd_en = 1'b1;
      end
      S_SCAN_CMP: begin
        if (stat.action == ACT_ABOVE) begin
          if (stat.rd_gt_arg) begin
            cmd.hold_found = 1'b1;
            cmd.idx_inc    = 1'b1;
            // match at the tail needs no compaction
            if (stat.idx_last) begin
              cmd.drop    = 1'b1;
              cmd.finish  = 1'b1;
              cmd.res_sel = RES_RDDATA;
            end
          end else if (stat.idx_last) begin
            cmd.finish     = 1'b1;
            cmd.take_fresh = stat.fresh_left;
            cmd.res_sel    = stat.fresh_left ? RES_FRESH : RES_EXHAUSTED;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end else begin
          if (stat.rd_eq_arg) begin
            cmd.finish  = 1'b1;
            cmd.res_sel = RES_INVALID;
          end else if (stat.idx_last) begin
            cmd.finish  = 1'b1;
            cmd.append  = 1'b1;
            cmd.res_sel = RES_ARG;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      S_SHIFT_RD: begin
        cmd.rd_en = 1'b1;
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        if (stat.idx_last) begin
          cmd.drop    = 1'b1;
          cmd.finish  = 1'b1;
          cmd.res_sel = RES_FOUND;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/ida_dp.sv =====
// datapath for the id allocator: recycle list ring memory, counters, result word
// depends on ida_pkg; commanded by ida_ctrl
module ida_dp
  import ida_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cmd_t     cmd_in,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  output logic     done,
  output rsp_t     rsp
);

  logic [ID_W-1:0]  mem [MAX_IDS];
  logic [ID_W-1:0]  rd_data;
  logic [ID_W-1:0]  rd_addr;
  logic [ID_W-1:0]  wr_addr;
  logic [ID_W-1:0]  wr_data;
  logic             wr_en;

  action_t          action;
  logic [ID_W-1:0]  arg;
  logic [ID_W-1:0]  head;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] next_fresh;
  logic [CNT_W-1:0] idx;
  logic [ID_W-1:0]  found_id;
  logic [ID_W-1:0]  res_id;
  status_t          res_status;

  // logical list position -> ring address
  assign rd_addr = cmd.rd_head ? head : ID_W'(head + idx[ID_W-1:0]);
  assign wr_en   = cmd.wr_shift | cmd.append;
  assign wr_addr = cmd.append ? ID_W'(head + count[ID_W-1:0])
                              : ID_W'(head + idx[ID_W-1:0] - ID_W'(1));
  assign wr_data = cmd.append ? arg : rd_data;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rd_data <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action <= cmd_in.action;
      arg    <= cmd_in.entity_id;
    end
    if (cmd.hold_found) found_id <= rd_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      count      <= '0;
      next_fresh <= CNT_W'(1);
      idx        <= '0;
    end else begin
      if (cmd.pop) head <= ID_W'(head + ID_W'(1));
      if (cmd.pop || cmd.drop) count <= count - CNT_W'(1);
      else if (cmd.append) count <= count + CNT_W'(1);
      if (cmd.take_fresh) next_fresh <= next_fresh + CNT_W'(1);
      if (cmd.idx_clr) idx <= '0;
      else if (cmd.idx_inc) idx <= idx + CNT_W'(1);
    end
  end

  always_comb begin
    stat.action       = action;
    stat.count_zero   = (count == '0);
    stat.fresh_left   = (next_fresh < CNT_W'(MAX_IDS));
    stat.arg_zero     = (arg == '0);
    stat.arg_ge_fresh = ({1'b0, arg} >= next_fresh);
    stat.rd_gt_arg    = (rd_data > arg);
    stat.rd_eq_arg    = (rd_data == arg);
    stat.idx_last     = ((idx + CNT_W'(1)) == count);
  end

  always_comb begin
    unique case (cmd.res_sel)
      RES_FRESH: begin
        res_id     = next_fresh[ID_W-1:0];
        res_status = ST_OK;
      end
      RES_RDDATA: begin
        res_id     = rd_data;
        res_status = ST_OK;
      end
      RES_FOUND: begin
        res_id     = found_id;
        res_status = ST_OK;
      end
      RES_ARG: begin
        res_id     = arg;
        res_status = ST_OK;
      end
      RES_EXHAUSTED: begin
        res_id     = '0;
        res_status = ST_EXHAUSTED;
      end
      default: begin
        res_id     = '0;
        res_status = ST_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp.result_id <= res_id;
      rsp.status    <= res_status;
    end
  end

endmodule

// ===== sv/id_allocator_with_recycle_list.sv =====
// Identifier allocator with an ordered recycle list of freed identifiers.
// Channels: a command word (cmd: action, entity_id) is taken at a rising edge
// with start high and busy low. Each command gives exactly one response word
// (rsp: result_id, status), shown for one cycle with done high; the receiver
// cannot stall it, so it must take the word in that cycle.
// Allocate-at-end, errors found on the argument and any action with an empty
// recycle list finish in the dispatch state; a plain allocate from the list
// adds one ring memory read. A free scans the list for a double free, one read
// and one compare per entry. Allocate-above-parent scans up to the match, then
// compacts the entries behind it, one read and one write per moved entry.
// One command at a time; busy stays high until the response is produced and a
// new command may be taken in the cycle done is high.
// Reset (rst, synchronous): recycle list empty, next fresh identifier 1, no
// memory clearing pass, ready in the cycle after reset drops.
// Depends on ida_pkg, ida_ctrl and ida_dp.
module id_allocator_with_recycle_list
  import ida_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic done,
  output rsp_t rsp
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  ida_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (dp_stat),
    .cmd   (dp_cmd)
  );

  ida_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd_in (cmd),
    .cmd    (dp_cmd),
    .stat   (dp_stat),
    .done   (done),
    .rsp    (rsp)
  );

  // a response only follows a command in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("response without a command in progress");

  a_ok_nonnull: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_OK) |-> (rsp.result_id != '0))
    else $error("null identifier handed out");

  a_err_null: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != ST_OK) |-> (rsp.result_id == '0))
    else $error("error response carries an identifier");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not start work");

endmodule

// ===== verif/testbench.sv =====
// self-checking bench for id_allocator_with_recycle_list: drives command words,
// tracks the recycle list and fresh counter, checks every response word
// depends on ida_pkg and the id_allocator_with_recycle_list rtl
`timescale 1ns / 1ps

module testbench;
  import ida_pkg::*;

  class id_pool_tracker;
    logic [ID_W-1:0]  recycled[$];
    logic [CNT_W-1:0] fresh;
    rsp_t             pending_rsp[$];
    int               errors;

    function new();
      fresh  = CNT_W'(1);
      errors = 0;
    endfunction

    function bit take_fresh(output logic [ID_W-1:0] id);
      id = '0;
      if (fresh >= MAX_IDS) return 1'b0;
      id    = fresh[ID_W-1:0];
      fresh = fresh + 1'b1;
      return 1'b1;
    endfunction

    // works out the response word for an accepted command
    function void log_command(cmd_t c);
      rsp_t            r;
      logic [ID_W-1:0] arg;
      bit              hit;
      r.result_id = '0;
      r.status    = ST_OK;
      arg         = c.entity_id;
      hit         = 1'b0;
      case (c.action)
        ACT_ALLOC: begin
          if (recycled.size() > 0) r.result_id = recycled.pop_front();
          else if (!take_fresh(r.result_id)) r.status = ST_EXHAUSTED;
        end
        ACT_ABOVE: begin
          if ({1'b0, arg} >= fresh) begin
            r.status = ST_INVALID;
          end else begin
            for (int i = 0; i < recycled.size(); i++) begin
              if (recycled[i] > arg) begin
                r.result_id = recycled[i];
                recycled.delete(i);
                hit = 1'b1;
                break;
              end
            end
            if (!hit && !take_fresh(r.result_id)) r.status = ST_EXHAUSTED;
          end
        end
        ACT_FRESH: begin
          if (!take_fresh(r.result_id)) r.status = ST_EXHAUSTED;
        end
        default: begin
          if (arg == '0 || {1'b0, arg} >= fresh) begin
            r.status = ST_INVALID;
          end else begin
            foreach (recycled[i]) if (recycled[i] == arg) hit = 1'b1;
            if (hit) begin
              r.status = ST_INVALID;
            end else begin
              recycled.push_back(arg);
              r.result_id = arg;
            end
          end
        end
      endcase
      if (r.status != ST_OK) r.result_id = '0;
      pending_rsp.push_back(r);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending_rsp.size() == 0) begin
        $error("response word with none outstanding: result_id %0d status %0d",
               got.result_id, got.status);
        errors++;
        return;
      end
      want = pending_rsp.pop_front();
      if (got.result_id !== want.result_id) begin
        $error("result_id: expected %0d, actual %0d", want.result_id, got.result_id);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_rsp.size();
    endfunction

    function int fresh_next();
      return int'(fresh);
    endfunction

    function int listed();
      return recycled.size();
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  cmd_t cmd   = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  id_pool_tracker tracker = new();
  bit             idle_en;

  id_allocator_with_recycle_list dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .rsp   (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) tracker.check_response(rsp);
  end

  // holds the word until it is taken, then maybe drops start for an idle gap
  task automatic issue(action_t a, logic [ID_W-1:0] arg);
    cmd_t c;
    c.action    = a;
    c.entity_id = arg;
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.log_command(c);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      cmd   <= cmd_t'($urandom);
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic random_cmd();
    int unsigned     roll;
    int unsigned     top;
    logic [ID_W-1:0] arg;
    roll = $urandom_range(0, 99);
    top  = tracker.fresh_next();
    if (roll < 15) begin
      // noise: any action, any argument
      arg = ID_W'($urandom);
      issue(action_t'($urandom_range(0, 3)), arg);
    end else if (roll < 45) begin
      arg = ID_W'($urandom_range(1, (top > 2) ? top - 1 : 1));
      issue(ACT_FREE, arg);
    end else if (roll < 70) begin
      issue(ACT_ALLOC, ID_W'($urandom));
    end else if (roll < 90) begin
      arg = ID_W'($urandom_range(0, (top > 1) ? top - 1 : 0));
      issue(ACT_ABOVE, arg);
    end else begin
      issue(ACT_FRESH, ID_W'($urandom));
    end
  endtask

  initial begin
    idle_en = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: every action, argument extremes, invalid arguments, double free
    issue(ACT_ALLOC, 10'd0);
    issue(ACT_ABOVE, 10'd0);
    issue(ACT_FRESH, 10'd1023);
    issue(ACT_ALLOC, 10'd1023);
    issue(ACT_FREE,  10'd0);
    issue(ACT_FREE,  10'd1023);
    issue(ACT_ABOVE, 10'd1023);
    issue(ACT_FREE,  10'd2);
    issue(ACT_FREE,  10'd2);
    issue(ACT_FREE,  10'd4);
    issue(ACT_FREE,  10'd1);
    issue(ACT_ABOVE, 10'd3);
    issue(ACT_ABOVE, 10'd2);
    issue(ACT_ALLOC, 10'd0);
    issue(ACT_ALLOC, 10'd0);
    issue(ACT_ALLOC, 10'd0);
    issue(ACT_FREE,  10'd3);
    issue(ACT_FREE,  10'd5);
    issue(ACT_ABOVE, 10'd0);
    issue(ACT_FREE,  10'd6);
    issue(ACT_FREE,  10'd6);

    for (int blk = 0; blk < 8; blk++) begin
      idle_en = 1'($urandom_range(0, 1));
      repeat (18) random_cmd();
    end

    // longer recycle list drawn from a larger pool of identifiers
    idle_en = 1'b1;
    repeat (40) issue(ACT_FRESH, ID_W'($urandom));
    repeat (40) issue(ACT_FREE, ID_W'($urandom_range(1, tracker.fresh_next() - 1)));
    for (int blk = 0; blk < 3; blk++) begin
      idle_en = 1'($urandom_range(0, 1));
      repeat (10) random_cmd();
    end
    idle_en = 1'b0;
    repeat (20) random_cmd();

    start <= 1'b0;
    while (tracker.outstanding() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
